@@ rtl/nonoverlap_substring_counter_core_defines.svh @@
// Assertion macros for the checker file of the substring counter.
// No dependencies; each file that asserts includes this header.
`ifndef NONOVERLAP_SUBSTRING_COUNTER_CORE_DEFINES_SVH
`define NONOVERLAP_SUBSTRING_COUNTER_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset
`define NSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included
`define NSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/nsc_pkg.sv @@
// Package of the substring counter: item type, field widths, command codes.
// No dependencies; used by the front, back and top-level RTL files.
`default_nettype none

package nsc_pkg;

    localparam int CFG_W      = 7;   // pattern_length register
    localparam int INDEX_W    = 6;   // pattern_index field
    localparam int BYTE_W     = 8;   // byte_value field
    localparam int COUNT_W    = 10;  // occurrence_count field
    localparam int OP_Q_DEPTH  = 2;  // queue between front and back
    localparam int RES_Q_DEPTH = 2;  // result queue

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // Classified item handed from front to back
    typedef struct packed {
        logic               is_text;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  data;      // lowercased for text bytes
        logic               line_end;  // only set on text bytes
    } t_op;

    // ASCII upper case to lower case, other bytes unchanged
    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nsc_fifo.sv @@
// Small first-in first-out queue built from registers.
// No dependencies; used for the item queue and the result queue.
`default_nettype none

module nsc_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsc_front.sv @@
// Front end: takes input transfers, classifies and lowercases them, queues them.
// Depends on nsc_pkg and nsc_fifo.
`default_nettype none

module nsc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic                         i_command,
    input  wire logic [nsc_pkg::INDEX_W-1:0]  i_pattern_index,
    input  wire logic [nsc_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire logic                         i_line_end,
    output nsc_pkg::t_op                      o_op,
    output logic                              o_op_valid,
    input  wire logic                         i_op_take
);

    localparam int OP_W = $bits(nsc_pkg::t_op);

    nsc_pkg::t_op    op_in;
    logic [OP_W-1:0] op_rdata;
    logic            op_empty;

    // Classify: text bytes are lowercased, line end only counts on text
    always_comb begin
        op_in.is_text  = (i_command == nsc_pkg::CMD_TEXT);
        op_in.index    = i_pattern_index;
        op_in.data     = op_in.is_text ? nsc_pkg::to_lower(i_byte_value) : i_byte_value;
        op_in.line_end = op_in.is_text && i_line_end;
    end

    nsc_fifo #(
        .WIDTH (OP_W),
        .DEPTH (nsc_pkg::OP_Q_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (op_in),
        .o_full  (o_full),
        .i_pop   (i_op_take),
        .o_rdata (op_rdata),
        .o_empty (op_empty)
    );

    assign o_op       = nsc_pkg::t_op'(op_rdata);
    assign o_op_valid = !op_empty;

endmodule

`default_nettype wire

@@ rtl/nsc_back.sv @@
// Back end: pattern store, byte window, match compare, line counters, result queue.
// Depends on nsc_pkg and nsc_fifo.
`default_nettype none

module nsc_back #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_LINE    = 512
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [nsc_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire nsc_pkg::t_op                i_op,
    input  wire logic                        i_op_valid,
    output logic                             o_op_take,
    input  wire logic                        i_pop,
    output logic                             o_empty,
    output logic [nsc_pkg::COUNT_W-1:0]      o_occurrence_count
);

    localparam int BW    = nsc_pkg::BYTE_W;
    localparam int WIN_W = BW * MAX_PATTERN;
    localparam int ADR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int LC_W  = $clog2(MAX_LINE + 1);
    localparam int SH_W  = LEN_W + 3;

    logic [nsc_pkg::CFG_W-1:0] r_pattern_length;
    logic [BW-1:0]             r_pattern [MAX_PATTERN];
    logic [WIN_W-1:0]          r_window, n_window;   // newest byte in lane 0
    logic [LEN_W-1:0]          r_since_match, n_since_match;
    logic [LC_W-1:0]           r_line_bytes, n_line_bytes;
    logic [LC_W-1:0]           r_match_count, n_match_count;

    logic [31:0]               len_full, cfg_ext, idx_ext, mc_ext;
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          shift_lanes;
    logic [WIN_W-1:0]          win_rev, win_aligned;
    logic [MAX_PATTERN-1:0]    lane_ok;
    logic                      window_eq, hit;
    logic                      res_full, res_push;
    logic [LEN_W-1:0]          since_inc;
    logic [LC_W-1:0]           line_inc, match_inc;

    assign o_op_take = i_op_valid && !res_full;

    // Effective pattern length: zero acts as one, clamp to the store depth
    always_comb begin
        cfg_ext = 32'(r_pattern_length);
        if (cfg_ext == 32'd0) begin
            len_full = 32'd1;
        end else if (cfg_ext > 32'(MAX_PATTERN)) begin
            len_full = 32'(MAX_PATTERN);
        end else begin
            len_full = cfg_ext;
        end
        len         = len_full[LEN_W-1:0];
        shift_lanes = LEN_W'(MAX_PATTERN) - len;
    end

    // Window after this byte; truncation drops the oldest lane
    assign n_window = WIN_W'({r_window, i_op.data});

    // Reverse the lanes, then shift so pattern byte k faces window lane len-1-k
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_rev
        assign win_rev[i*BW +: BW] = n_window[(MAX_PATTERN-1-i)*BW +: BW];
    end
    assign win_aligned = win_rev >> SH_W'({shift_lanes, 3'b000});

    // Per-lane compare, lanes beyond the length always pass
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
        assign lane_ok[k] = (win_aligned[k*BW +: BW] == r_pattern[k]) ||
                            (LEN_W'(k) >= len);
    end
    assign window_eq = &lane_ok;

    // Saturating counter steps
    assign since_inc = (r_since_match < LEN_W'(MAX_PATTERN)) ?
                       r_since_match + LEN_W'(1) : r_since_match;
    assign line_inc  = (r_line_bytes < LC_W'(MAX_LINE)) ?
                       r_line_bytes + LC_W'(1) : r_line_bytes;
    assign match_inc = (r_match_count < LC_W'(MAX_LINE)) ?
                       r_match_count + LC_W'(1) : r_match_count;

    assign hit = (32'(line_inc) >= 32'(len)) && (since_inc >= len) && window_eq;

    // Line state update for a text byte
    always_comb begin
        n_since_match = r_since_match;
        n_line_bytes  = r_line_bytes;
        n_match_count = r_match_count;
        res_push      = 1'b0;
        if (o_op_take && i_op.is_text) begin
            n_line_bytes  = line_inc;
            n_since_match = hit ? '0 : since_inc;
            n_match_count = hit ? match_inc : r_match_count;
            if (i_op.line_end) begin
                res_push      = 1'b1;
                n_line_bytes  = '0;
                n_match_count = '0;
                n_since_match = LEN_W'(MAX_PATTERN);
            end
        end
    end

    // Count of the finished line, including a match on the closing byte
    assign mc_ext = 32'(hit ? match_inc : r_match_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= nsc_pkg::CFG_W'(1);
            r_since_match    <= LEN_W'(MAX_PATTERN);
            r_line_bytes     <= '0;
            r_match_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pattern_length <= i_cfg_wdata;
            end
            r_since_match <= n_since_match;
            r_line_bytes  <= n_line_bytes;
            r_match_count <= n_match_count;
        end
    end

    // Byte window shifts on each text byte
    always_ff @(posedge i_clk) begin
        if (o_op_take && i_op.is_text) begin
            r_window <= n_window;
        end
    end

    // Pattern store, one write port; indexes past the depth are dropped
    assign idx_ext = 32'(i_op.index);
    always_ff @(posedge i_clk) begin
        if (o_op_take && !i_op.is_text && (idx_ext < 32'(MAX_PATTERN))) begin
            r_pattern[idx_ext[ADR_W-1:0]] <= i_op.data;
        end
    end

    nsc_fifo #(
        .WIDTH (nsc_pkg::COUNT_W),
        .DEPTH (nsc_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (mc_ext[nsc_pkg::COUNT_W-1:0]),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_rdata (o_occurrence_count),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

@@ rtl/nonoverlap_substring_counter_core.sv @@
// Top level of the non-overlapping substring counter.
// Depends on nsc_pkg, nsc_front, nsc_back (and nsc_fifo below them).
//
// Usage:
//  - Input queue: an item transfers on a clock edge with push high and full low.
//    Command 0 writes byte_value to pattern entry pattern_index; command 1
//    feeds one text byte, line_end marking the last byte of a line.
//  - Result queue: while empty is low the oldest line count is on
//    o_occurrence_count; it transfers on an edge with pop high.
//    One result per text byte with line_end set, none otherwise.
//  - Config: i_cfg_we writes i_cfg_wdata to pattern_length; write only idle.
//  - Throughput: one item per cycle while the result queue has room; the
//    back-end compare is combinational (barrel align, byte compare per lane).
//  - Result path: a closing byte goes through the item queue, then the back
//    end into the result queue, from which its result can be popped.
//  - Stall: the 2-entry result queue fills, the back end stops, then the
//    2-entry item queue fills and full rises.
//  - Reset: both queues empty, pattern_length = 1, line counters cleared;
//    the pattern store holds garbage until written.
`default_nettype none

module nonoverlap_substring_counter_core #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_LINE    = 512
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        i_command,
    input  wire logic [nsc_pkg::INDEX_W-1:0] i_pattern_index,
    input  wire logic [nsc_pkg::BYTE_W-1:0]  i_byte_value,
    input  wire logic                        i_line_end,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [nsc_pkg::COUNT_W-1:0]      o_occurrence_count,
    input  wire logic                        i_cfg_we,
    input  wire logic [nsc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    nsc_pkg::t_op op;
    logic         op_valid;
    logic         op_take;

    // Front: classify and queue
    nsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_command       (i_command),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .i_line_end      (i_line_end),
        .o_op            (op),
        .o_op_valid      (op_valid),
        .i_op_take       (op_take)
    );

    // Back: execute and queue results
    nsc_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_LINE    (MAX_LINE)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_op               (op),
        .i_op_valid         (op_valid),
        .o_op_take          (op_take),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_occurrence_count (o_occurrence_count)
    );

endmodule

`default_nettype wire

@@ rtl/nsc_checker.sv @@
// Port-level checker for the substring counter, bound to the top level.
// Depends on nonoverlap_substring_counter_core_defines.svh.
`default_nettype none
`include "nonoverlap_substring_counter_core_defines.svh"

module nsc_checker #(
    parameter int MAX_LINE = 512
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [9:0] o_occurrence_count
);

    // Reset leaves both queues empty
    `NSC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty && !full, "queues not empty after reset")

    // A waiting result holds until it is taken
    `NSC_ASSERT(a_result_holds, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_occurrence_count), "waiting result changed")

    // The input queue only fills through an input transfer
    `NSC_ASSERT(a_full_by_push, i_clk, i_rst_n, $rose(full) |-> $past(push), "full rose without a transfer in")

    // The result queue only drains through a result transfer
    `NSC_ASSERT(a_empty_by_pop, i_clk, i_rst_n, $rose(empty) |-> $past(pop), "empty rose without a transfer out")

    // A line never counts more matches than its saturation limit
    `NSC_ASSERT(a_count_limit, i_clk, i_rst_n, !empty |-> (32'(o_occurrence_count) <= 32'(MAX_LINE)), "count above line limit")

endmodule

bind nonoverlap_substring_counter_core nsc_checker #(
    .MAX_LINE (MAX_LINE)
) u_nsc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .push               (push),
    .full               (full),
    .empty              (empty),
    .pop                (pop),
    .o_occurrence_count (o_occurrence_count)
);

`default_nettype wire

@@ test/tb_nonoverlap_substring_counter_core.sv @@
`timescale 1ns / 1ps
// Testbench of nonoverlap_substring_counter_core: directed and random text lines,
// each line count checked against a line counter kept inside the bench.
// Depends on nsc_pkg and the block's RTL; needs nothing at run time.

module tb_nonoverlap_substring_counter_core;

    localparam int INDEX_W     = nsc_pkg::INDEX_W;
    localparam int BYTE_W      = nsc_pkg::BYTE_W;
    localparam int COUNT_W     = nsc_pkg::COUNT_W;
    localparam int CFG_W       = nsc_pkg::CFG_W;
    localparam int PAT_DEPTH   = 64;
    localparam int LINE_LIMIT  = 512;
    localparam int SETTLE      = 6;       // cycles for items that make no result
    localparam int CYCLE_LIMIT = 400000;

    // DUT ports
    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               full;
    logic               i_command   = nsc_pkg::CMD_PATTERN;
    logic [INDEX_W-1:0] i_pattern_index = '0;
    logic [BYTE_W-1:0]  i_byte_value    = '0;
    logic               i_line_end  = 1'b0;
    logic               empty;
    logic               pop         = 1'b0;
    logic [COUNT_W-1:0] o_occurrence_count;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    // Bench copy of the counter state
    logic [BYTE_W-1:0]  pat_mem [PAT_DEPTH];
    logic [BYTE_W-1:0]  recent  [PAT_DEPTH];   // [0] is the newest text byte
    int unsigned        since_hit;
    int unsigned        line_len;
    int unsigned        hits;
    logic [CFG_W-1:0]   len_reg;
    logic [COUNT_W-1:0] line_counts_due [$];

    int unsigned        failures      = 0;
    int unsigned        items_sent    = 0;
    int unsigned        cycles        = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        take_idle_pct = 0;
    logic [COUNT_W-1:0] due_count;

    nonoverlap_substring_counter_core #(
        .MAX_PATTERN(PAT_DEPTH),
        .MAX_LINE   (LINE_LIMIT)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_pattern_index   (i_pattern_index),
        .i_byte_value      (i_byte_value),
        .i_line_end        (i_line_end),
        .empty             (empty),
        .pop               (pop),
        .o_occurrence_count(o_occurrence_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Pattern bytes in use: 0 acts as 1, anything above the store size as the store size
    function automatic int unsigned span_of(input logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > PAT_DEPTH) return PAT_DEPTH;
        return 32'(r);
    endfunction

    // Advance the line counter by one transferred item; queue the count at line end
    function automatic void advance_counter(input logic cmd, input logic [INDEX_W-1:0] idx,
                                            input logic [BYTE_W-1:0] b, input logic le);
        int unsigned span;
        int unsigned k;
        logic        hit;
        if (cmd == nsc_pkg::CMD_PATTERN) begin
            pat_mem[idx] = b;
            return;
        end
        for (k = PAT_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;   // fold A..Z only
        if (line_len < LINE_LIMIT) line_len++;
        if (since_hit < PAT_DEPTH) since_hit++;
        span = span_of(len_reg);
        // a hit needs a full window inside the line and a full pattern since the last hit
        if (line_len >= span && since_hit >= span) begin
            hit = 1'b1;
            for (k = 0; k < span; k++) begin
                if (recent[span-1-k] != pat_mem[k]) hit = 1'b0;
            end
            if (hit) begin
                if (hits < LINE_LIMIT) hits++;
                since_hit = 0;
            end
        end
        if (le) begin
            line_counts_due.push_back(COUNT_W'(hits));
            hits      = 0;
            line_len  = 0;
            since_hit = PAT_DEPTH;
        end
    endfunction

    // Result side: check each transfer, then decide whether to take the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (line_counts_due.size() == 0) begin
                    $error("occurrence_count: no result expected, got %0d", o_occurrence_count);
                    failures++;
                end else begin
                    due_count = line_counts_due.pop_front();
                    if (o_occurrence_count !== due_count) begin
                        $error("occurrence_count: expected %0d, got %0d",
                               due_count, o_occurrence_count);
                        failures++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // One item; returns at the edge where it transfers, push left high
    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] b, input logic le);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_command       <= cmd;
        i_pattern_index <= idx;
        i_byte_value    <= b;
        i_line_end      <= le;
        do @(posedge i_clk); while (full);
        advance_counter(cmd, idx, b, le);
        items_sent++;
    endtask

    // Text line from a string, the last character closes the line
    task automatic send_line(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_item(nsc_pkg::CMD_TEXT, INDEX_W'($urandom_range(PAT_DEPTH - 1)), s[k],
                      k == s.len() - 1);
        end
    endtask

    task automatic load_pattern(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_item(nsc_pkg::CMD_PATTERN, INDEX_W'(k), s[k], 1'b0);
        end
    endtask

    // Stop sending and wait until every line count has come back
    task automatic drain_results();
        push <= 1'b0;
        while (line_counts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        len_reg = v;
    endtask

    function automatic logic [BYTE_W-1:0] pattern_letter();
        case ($urandom_range(19))
            0:       return "A";                     // upper case never matches
            1:       return BYTE_W'($urandom);
            2, 3, 4: return "c";
            default: return ($urandom_range(1) != 0) ? "a" : "b";
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] text_letter();
        case ($urandom_range(9))
            0, 1, 2, 3: return "a";
            4, 5:       return "b";
            6:          return "A";
            7:          return "B";
            8:          return "c";
            default:    return BYTE_W'($urandom);
        endcase
    endfunction

    // Every store entry written once, random bytes, line_end ignored on pattern writes
    task automatic test_pattern_load();
        int j;
        for (j = 0; j < PAT_DEPTH; j++) begin
            send_item(nsc_pkg::CMD_PATTERN, INDEX_W'(j), BYTE_W'($urandom),
                      1'($urandom_range(1)));
        end
    endtask

    // Reset length of one, case folding at the letter range edges, byte extremes
    task automatic test_case_folding();
        load_pattern("a");
        send_line("aAba");
        send_item(nsc_pkg::CMD_TEXT, '0, 8'h00, 1'b0);
        send_item(nsc_pkg::CMD_TEXT, '1, 8'hFF, 1'b1);
        load_pattern("z");
        send_line("@Z[z`{");
    endtask

    // Non-overlap, match on the closing byte, no match across lines
    task automatic test_nonoverlap();
        load_pattern("aba");
        set_length(CFG_W'(3));
        send_line("ababa");
        send_line("abababa");
        send_line("xxaba");
        send_line("ab");
        send_line("a");
        send_item(nsc_pkg::CMD_TEXT, '0, "a", 1'b0);
        send_item(nsc_pkg::CMD_TEXT, '0, "b", 1'b0);
        send_item(nsc_pkg::CMD_PATTERN, 6'd3, "c", 1'b1);     // pattern write inside a line
        send_item(nsc_pkg::CMD_TEXT, '0, "A", 1'b1);
    endtask

    // Full-size pattern, register above the store size, register of zero
    task automatic test_length_extremes();
        int j;
        for (j = 0; j < PAT_DEPTH; j++) begin
            send_item(nsc_pkg::CMD_PATTERN, INDEX_W'(j), "q", 1'b0);
        end
        set_length(CFG_W'(PAT_DEPTH));
        for (j = 0; j < PAT_DEPTH; j++) begin
            send_item(nsc_pkg::CMD_TEXT, '0, "Q", j == PAT_DEPTH - 1);
        end
        set_length('1);
        for (j = 0; j < PAT_DEPTH + 8; j++) begin
            send_item(nsc_pkg::CMD_TEXT, '0, ($urandom_range(1) != 0) ? "q" : "Q",
                      j == PAT_DEPTH + 7);
        end
        set_length('0);
        send_line("qQxq");
    endtask

    // Line longer than the line limit, every byte a hit: count saturates
    task automatic test_long_line();
        int j;
        load_pattern("a");
        set_length(CFG_W'(1));
        for (j = 0; j < LINE_LIMIT + 4; j++) begin
            send_item(nsc_pkg::CMD_TEXT, '0, ($urandom_range(1) != 0) ? "a" : "A",
                      j == LINE_LIMIT + 3);
        end
    endtask

    // Random pattern, length and lines; text mostly follows the pattern to make hits
    task automatic random_phase(input int unsigned n_items);
        int unsigned      first;
        int unsigned      span;
        int unsigned      n_lines;
        int unsigned      line_sz;
        int unsigned      ln;
        int unsigned      j;
        logic [CFG_W-1:0] reg_val;
        logic             follow;
        logic             le;
        logic [BYTE_W-1:0] b;
        first = items_sent;
        while (items_sent - first < n_items) begin
            case ($urandom_range(19))
                0:       reg_val = '0;
                1:       reg_val = CFG_W'($urandom_range(127, PAT_DEPTH + 1));
                2:       reg_val = CFG_W'(PAT_DEPTH);
                3, 4:    reg_val = CFG_W'($urandom_range(8, 5));
                default: reg_val = CFG_W'($urandom_range(4, 1));
            endcase
            span = span_of(reg_val);
            for (j = 0; j < span; j++) begin
                send_item(nsc_pkg::CMD_PATTERN, INDEX_W'(j), pattern_letter(),
                          1'($urandom_range(1)));
            end
            set_length(reg_val);
            n_lines = (span > 8) ? 1 : $urandom_range(6, 1);
            for (ln = 0; ln < n_lines; ln++) begin
                follow  = 1'($urandom_range(1));
                line_sz = $urandom_range(3 * span + 4, 1);
                for (j = 0; j < line_sz; j++) begin
                    // stray pattern write in the middle of the text
                    if ($urandom_range(31) == 0) begin
                        send_item(nsc_pkg::CMD_PATTERN,
                                  INDEX_W'($urandom_range(PAT_DEPTH - 1)),
                                  BYTE_W'($urandom), 1'($urandom_range(1)));
                    end
                    if (follow && $urandom_range(9) != 0) begin
                        b = pat_mem[j % span];
                        if (b >= "a" && b <= "z" && $urandom_range(3) == 0) b = b ^ 8'h20;
                    end else begin
                        b = text_letter();
                    end
                    // the last line is sometimes left open across the length change
                    le = (j == line_sz - 1) && !(ln == n_lines - 1 && $urandom_range(6) == 0);
                    send_item(nsc_pkg::CMD_TEXT, INDEX_W'($urandom_range(PAT_DEPTH - 1)),
                              b, le);
                end
                if ($urandom_range(9) == 0) drain_results();
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 32;
        take_idle_pct = 69;
        random_phase(40);
        send_idle_pct = 69;
        take_idle_pct = 32;
        random_phase(40);
        drain_results();
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(40);
    endtask

    initial begin : run_tests
        int j;
        for (j = 0; j < PAT_DEPTH; j++) recent[j] = '0;
        since_hit = PAT_DEPTH;
        line_len  = 0;
        hits      = 0;
        len_reg   = 1;
        send_idle_pct = 32;
        take_idle_pct = 69;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pattern_load();
        test_case_folding();
        test_nonoverlap();
        test_length_extremes();
        test_long_line();
        test_random_traffic();

        drain_results();
        if (failures == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
